// ===== rtl/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Shared widths, operation and status codes, and control types for the
// generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  // payload field widths
  localparam int FUNC_W = 2;
  localparam int SLOT_W = 7;
  localparam int GEN_W  = 32;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input word and launch memory reads
    logic exec;     // perform the operation and load the output register
  } gha_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_hold;  // output register full and not being taken
  } gha_sts_t;

endpackage

// ===== rtl/gha_in_if.sv =====
// ----------------------------------------------------------------------------
// gha_in_if
// Request channel: valid/ready handshake carrying one operation word.
// ----------------------------------------------------------------------------
interface gha_in_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::FUNC_W-1:0]  func;
  logic [gha_pkg::SLOT_W-1:0]  handle_slot;
  logic [gha_pkg::GEN_W-1:0]   handle_generation;

  modport source (output valid, output func, output handle_slot,
                  output handle_generation, input ready);
  modport sink   (input valid, input func, input handle_slot,
                  input handle_generation, output ready);
endinterface

// ===== rtl/gha_out_if.sv =====
// ----------------------------------------------------------------------------
// gha_out_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface gha_out_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::STAT_W-1:0]  status;
  logic [gha_pkg::SLOT_W-1:0]  out_slot;
  logic [gha_pkg::GEN_W-1:0]   out_generation;

  modport source (output valid, output status, output out_slot,
                  output out_generation, input ready);
  modport sink   (input valid, input status, input out_slot,
                  input out_generation, output ready);
endinterface

// ===== rtl/gha_ctrl.sv =====
// ----------------------------------------------------------------------------
// gha_ctrl
// Two-state sequencer: accept a request word, then execute it once the
// output register can take the result.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gha_pkg::gha_sts_t sts,
  output gha_pkg::gha_cmd_t cmd
);
  import gha_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_hold) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/gha_dpath.sv =====
// ----------------------------------------------------------------------------
// gha_dpath
// Slot table, free stack, counters and output register. The slot table
// holds {occupied, generation} per slot; only entries below the fill count
// are ever used, so neither memory needs clearing.
// ----------------------------------------------------------------------------
module gha_dpath #(
  parameter int SLOT_COUNT = 64,
  parameter int GEN_BITS   = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gha_pkg::gha_cmd_t           cmd,
  output gha_pkg::gha_sts_t           sts,
  input  logic [gha_pkg::FUNC_W-1:0]  in_func,
  input  logic [gha_pkg::SLOT_W-1:0]  in_handle_slot,
  input  logic [gha_pkg::GEN_W-1:0]   in_handle_generation,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [gha_pkg::STAT_W-1:0]  out_status,
  output logic [gha_pkg::SLOT_W-1:0]  out_slot,
  output logic [gha_pkg::GEN_W-1:0]   out_generation
);
  import gha_pkg::*;

  localparam int SIDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int GEN_X  = (GEN_BITS > GEN_W) ? GEN_BITS : GEN_W;

  // memories
  logic [GEN_BITS:0]   tbl_mem [SLOT_COUNT];
  logic [SIDX_W-1:0]   fs_mem  [SLOT_COUNT];

  // control state
  logic [CNT_W-1:0]    free_count_r, free_count_nxt;
  logic [CNT_W-1:0]    slots_used_r, slots_used_nxt;
  logic [GEN_BITS-1:0] next_gen_r,   next_gen_nxt;
  logic                out_valid_r,  out_valid_nxt;

  // captured request and read data
  logic [FUNC_W-1:0]   func_r;
  logic                range_ok_r;
  logic [SIDX_W-1:0]   hidx_r;
  logic [GEN_BITS-1:0] hgen_r;
  logic [GEN_BITS:0]   tbl_rd_r;
  logic [SIDX_W-1:0]   fs_rd_r;

  // output register
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r,   slot_nxt;
  logic [GEN_W-1:0]    gen_r,    gen_nxt;

  // handle decode at capture
  logic [CMP_W-1:0]    hs_ext;
  logic [CMP_W-1:0]    hs_m1;
  logic                range_ok;
  logic [GEN_X-1:0]    hgen_ext;
  logic [CNT_W-1:0]    fc_m1;

  assign hs_ext   = CMP_W'(in_handle_slot);
  assign hs_m1    = hs_ext - CMP_W'(1);
  assign range_ok = (hs_ext != '0) && (hs_ext <= CMP_W'(slots_used_r));
  assign hgen_ext = GEN_X'(in_handle_generation);
  assign fc_m1    = free_count_r - CNT_W'(1);

  // execute-stage decode
  logic                handle_ok;
  logic [SIDX_W-1:0]   alloc_idx;
  logic [CMP_W-1:0]    alloc_slot;
  logic [GEN_X-1:0]    gen_ext;
  logic [GEN_BITS-1:0] gen_inc;
  logic                tbl_we;
  logic [SIDX_W-1:0]   tbl_wa;
  logic [GEN_BITS:0]   tbl_wd;
  logic                fs_we;

  assign handle_ok  = range_ok_r && tbl_rd_r[GEN_BITS] && (tbl_rd_r[GEN_BITS-1:0] == hgen_r);
  assign alloc_idx  = (free_count_r != '0) ? fs_rd_r : slots_used_r[SIDX_W-1:0];
  assign alloc_slot = CMP_W'(alloc_idx) + CMP_W'(1);
  assign gen_ext    = GEN_X'(next_gen_r);
  assign gen_inc    = next_gen_r + GEN_BITS'(1);

  // operation
  always_comb begin
    free_count_nxt = free_count_r;
    slots_used_nxt = slots_used_r;
    next_gen_nxt   = next_gen_r;
    status_nxt     = ST_INVALID;
    slot_nxt       = '0;
    gen_nxt        = '0;
    tbl_we         = 1'b0;
    tbl_wa         = hidx_r;
    tbl_wd         = {1'b0, hgen_r};
    fs_we          = 1'b0;
    case (func_r)
      FUNC_ALLOC: begin
        if ((free_count_r != '0) || (slots_used_r < CNT_W'(SLOT_COUNT))) begin
          if (free_count_r != '0) begin
            free_count_nxt = fc_m1;
          end else begin
            slots_used_nxt = slots_used_r + CNT_W'(1);
          end
          tbl_we       = 1'b1;
          tbl_wa       = alloc_idx;
          tbl_wd       = {1'b1, next_gen_r};
          next_gen_nxt = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
          status_nxt   = ST_OK;
          slot_nxt     = alloc_slot[SLOT_W-1:0];
          gen_nxt      = gen_ext[GEN_W-1:0];
        end else begin
          status_nxt = ST_FULL;
        end
      end
      FUNC_CHECK: begin
        status_nxt = handle_ok ? ST_OK : ST_INVALID;
      end
      FUNC_RELEASE: begin
        if (handle_ok && (free_count_r < CNT_W'(SLOT_COUNT))) begin
          tbl_we         = 1'b1;
          fs_we          = 1'b1;
          free_count_nxt = free_count_r + CNT_W'(1);
          status_nxt     = ST_OK;
        end
      end
      default: status_nxt = ST_INVALID;
    endcase
  end

  // output handshake
  assign sts.out_hold = out_valid_r && !out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_count_r <= '0;
      slots_used_r <= '0;
      next_gen_r   <= GEN_BITS'(1);
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.exec) begin
        free_count_r <= free_count_nxt;
        slots_used_r <= slots_used_nxt;
        next_gen_r   <= next_gen_nxt;
      end
    end
  end

  // request capture and output payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= in_func;
      range_ok_r <= range_ok;
      hidx_r     <= hs_m1[SIDX_W-1:0];
      hgen_r     <= hgen_ext[GEN_BITS-1:0];
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      gen_r    <= gen_nxt;
    end
  end

  // slot table: read at capture, write at execute
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tbl_rd_r <= tbl_mem[hs_m1[SIDX_W-1:0]];
    end
    if (cmd.exec && tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
  end

  // free stack: top read at capture, push at execute
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fs_rd_r <= fs_mem[fc_m1[SIDX_W-1:0]];
    end
    if (cmd.exec && fs_we) begin
      fs_mem[free_count_r[SIDX_W-1:0]] <= hidx_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_slot       = slot_r;
  assign out_generation = gen_r;

endmodule

// ===== rtl/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Generational handle table: allocate, check and release of slot handles.
// ----------------------------------------------------------------------------
// Each request word has a capture step, which reads the slot table entry and
// the free stack top into registers, and an execute step, which compares,
// updates the tables and loads the result register. A request is taken only
// while no other is in flight; a result held by the sink delays the execute
// step. Freed slots are reused last-in first-out, otherwise never-used slots
// are handed out in order. Generations come from one counter that starts at
// 1 and skips 0 on wrap. No clearing pass runs after reset: entries above the
// fill count are never used, so requests are accepted straight out of reset.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
  parameter int SLOT_COUNT = 64,
  parameter int GEN_BITS   = 32
) (
  input logic     clk,
  input logic     rst_n,
  gha_in_if.sink  in_ch,
  gha_out_if.source out_ch
);
  import gha_pkg::*;

  gha_cmd_t cmd;
  gha_sts_t sts;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gha_dpath #(
    .SLOT_COUNT (SLOT_COUNT),
    .GEN_BITS   (GEN_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_func              (in_ch.func),
    .in_handle_slot       (in_ch.handle_slot),
    .in_handle_generation (in_ch.handle_generation),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_status           (out_ch.status),
    .out_slot             (out_ch.out_slot),
    .out_generation       (out_ch.out_generation)
  );

  // one request in flight at a time
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // a new result only comes from an execute cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.exec))
    else $error("result word appeared without execute");

  // a granted slot always carries ok status and a nonzero generation
  a_grant_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.out_slot != '0)) |->
      ((out_ch.status == ST_OK) && (out_ch.out_generation != '0)))
    else $error("slot granted with bad status or zero generation");

  // execute never fires while a result is stuck at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !cmd.exec)
    else $error("result register overwritten while held");

endmodule
